>>> design/c8fpr_pkg.sv
// Package: shared types, codes and CRC-8 helpers for the framed packet receiver.
package c8fpr_pkg;

	// Bus-slave event codes
	typedef enum logic [1:0] {
		FUNC_ADDR    = 2'd0,
		FUNC_DATA    = 2'd1,
		FUNC_OTHER   = 2'd2,
		FUNC_CONSUME = 2'd3
	} func_t;

	// Frame status codes
	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_BAD_END = 2'd1,
		STATUS_BAD_CRC = 2'd2
	} status_t;

	typedef struct packed {
		func_t      func;
		logic [7:0] bus_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] command;
		logic [7:0] payload;
		status_t    frame_status;
	} out_item_t;

	// Stage-one handshake towards the input and output registers
	typedef struct packed {
		logic advance;
		logic res_valid;
	} stage_ctl_t;

	localparam int FRAME_LEN  = 5;
	localparam int POS_W      = 3;
	localparam int ADDR_W     = 7;
	localparam int CRC_MSG_W  = 24;
	localparam logic [7:0] START_MARK = 8'h3A;
	localparam logic [7:0] END_MARK   = 8'h0A;
	localparam logic [8:0] CRC_POLY_FULL = 9'h107;

	localparam logic [POS_W-1:0] POS_START = POS_W'(0);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LEN - 1);
	localparam logic [POS_W-1:0] POS_DONE  = POS_W'(FRAME_LEN);

	// Residue of x^(i+8) mod P for every message bit; evaluated at elaboration
	function automatic logic [CRC_MSG_W-1:0][7:0] crc_cols();
		logic [CRC_MSG_W-1:0][7:0] cols;
		logic [8:0] v;
		v = 9'h001;
		for (int k = 0; k < 8; k++) begin
			v = v << 1;
			if (v[8]) v = v ^ CRC_POLY_FULL;
		end
		for (int i = 0; i < CRC_MSG_W; i++) begin
			cols[i] = v[7:0];
			v = v << 1;
			if (v[8]) v = v ^ CRC_POLY_FULL;
		end
		return cols;
	endfunction

	localparam logic [CRC_MSG_W-1:0][7:0] CRC_COLS = crc_cols();

	// CRC-8 (poly 0x07, init 0) of a 24-bit message as a parallel XOR matrix
	function automatic logic [7:0] crc8_msg(input logic [CRC_MSG_W-1:0] msg);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < CRC_MSG_W; i++) begin
			if (msg[i]) acc = acc ^ CRC_COLS[i];
		end
		return acc;
	endfunction

endpackage

>>> design/crc8_framed_packet_receiver_top.sv
// Top level: framed packet receiver with CRC-8 check over bus-slave events.
//
// Input channel (in_valid/in_ready/in_data) carries one bus-slave event per
// transfer: address write, data byte, other status or frame consumed.
// Output channel (out_valid/out_ready/out_data) carries one result per
// completed five-byte frame: command, payload and frame status.
// cfg_we/cfg_wdata write the seven-bit own address used as the first CRC byte.
// An event is registered, then evaluated by the framing logic combinationally;
// a result is loaded into the output register at the edge at which its event
// leaves the input register.
// Throughput is one event per cycle, set by the single framing stage, except
// while the receiver stalls with a result waiting: events that produce no
// result keep flowing; only the next frame-completing byte waits in the input
// register, and in_ready drops until the output register is free.
// Reset clears position, held flag, own address and both valid flags.
module crc8_framed_packet_receiver_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  c8fpr_pkg::in_item_t           in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output c8fpr_pkg::out_item_t          out_data,
	input  logic                          cfg_we,
	input  logic [c8fpr_pkg::ADDR_W-1:0]  cfg_wdata
);

	c8fpr_pkg::stage_ctl_t ctl;
	c8fpr_pkg::in_item_t   item_s1;
	c8fpr_pkg::out_item_t  result;
	logic                  valid_s1;
	logic                  out_busy;

	c8fpr_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.ctl      (ctl),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	c8fpr_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.out_busy  (out_busy),
		.ctl       (ctl),
		.result    (result)
	);

	c8fpr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.result    (result),
		.out_busy  (out_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> design/c8fpr_in_reg.sv
// Input register: holds one accepted event for the framing stage.
module c8fpr_in_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  c8fpr_pkg::in_item_t  in_data,
	input  c8fpr_pkg::stage_ctl_t ctl,
	output logic                 valid_s1,
	output c8fpr_pkg::in_item_t  item_s1
);

	// Take a new event when the stage is empty or empties this cycle
	assign in_ready = !valid_s1 || ctl.advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (ctl.advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture payload on each transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

endmodule

>>> design/c8fpr_framer.sv
// Framer: frame position, held flag, stored bytes, CRC check and result build.
module c8fpr_framer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [c8fpr_pkg::ADDR_W-1:0]  cfg_wdata,
	input  logic                          valid_s1,
	input  c8fpr_pkg::in_item_t           item_s1,
	input  logic                          out_busy,
	output c8fpr_pkg::stage_ctl_t         ctl,
	output c8fpr_pkg::out_item_t          result
);

	logic [c8fpr_pkg::ADDR_W-1:0] slave_addr_q;
	logic [c8fpr_pkg::POS_W-1:0]  pos_q;
	logic                         held_q;
	logic [7:0]                   cmd_q;
	logic [7:0]                   data_q;
	logic [7:0]                   chk_q;

	logic       take;
	logic       complete;
	logic [7:0] crc_calc;

	// Decide whether the byte enters the frame
	always_comb begin
		take = (item_s1.func == c8fpr_pkg::FUNC_DATA) && !held_q &&
			(pos_q < c8fpr_pkg::POS_DONE) &&
			!((pos_q == c8fpr_pkg::POS_START) && (item_s1.bus_byte != c8fpr_pkg::START_MARK));
		complete = take && (pos_q == c8fpr_pkg::POS_LAST);
		ctl.res_valid = valid_s1 && complete;
		// Stall only when a result must go out and the output is still full
		ctl.advance = valid_s1 && !(complete && out_busy);
	end

	// Check end mark first, then the CRC over address, command and data
	assign crc_calc = c8fpr_pkg::crc8_msg({1'b0, slave_addr_q, cmd_q, data_q});

	always_comb begin
		result.command = cmd_q;
		result.payload = data_q;
		if (item_s1.bus_byte != c8fpr_pkg::END_MARK) begin
			result.frame_status = c8fpr_pkg::STATUS_BAD_END;
		end else if (crc_calc != chk_q) begin
			result.frame_status = c8fpr_pkg::STATUS_BAD_CRC;
		end else begin
			result.frame_status = c8fpr_pkg::STATUS_OK;
		end
	end

	// Own address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= '0;
		end else if (cfg_we) begin
			slave_addr_q <= cfg_wdata;
		end
	end

	// Advance position and held flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= c8fpr_pkg::POS_START;
			held_q <= 1'b0;
		end else if (ctl.advance) begin
			unique case (item_s1.func)
				c8fpr_pkg::FUNC_ADDR: begin
					pos_q <= c8fpr_pkg::POS_START;
				end
				c8fpr_pkg::FUNC_CONSUME: begin
					held_q <= 1'b0;
				end
				c8fpr_pkg::FUNC_DATA: begin
					if (take) begin
						pos_q <= pos_q + c8fpr_pkg::POS_W'(1);
					end
					if (complete) begin
						held_q <= 1'b1;
					end
				end
				c8fpr_pkg::FUNC_OTHER: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Store command, data and checksum bytes
	always_ff @(posedge clk) begin
		if (ctl.advance && take) begin
			if (pos_q == c8fpr_pkg::POS_W'(1)) cmd_q  <= item_s1.bus_byte;
			if (pos_q == c8fpr_pkg::POS_W'(2)) data_q <= item_s1.bus_byte;
			if (pos_q == c8fpr_pkg::POS_W'(3)) chk_q  <= item_s1.bus_byte;
		end
	end

endmodule

>>> design/c8fpr_out_reg.sv
// Output register: holds a finished frame result until the receiver takes it.
module c8fpr_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  c8fpr_pkg::stage_ctl_t ctl,
	input  c8fpr_pkg::out_item_t  result,
	output logic                  out_busy,
	output logic                  out_valid,
	input  logic                  out_ready,
	output c8fpr_pkg::out_item_t  out_data
);

	logic load;

	assign load     = ctl.advance && ctl.res_valid;
	assign out_busy = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Hold result until transfer
	always_ff @(posedge clk) begin
		if (load) begin
			out_data <= result;
		end
	end

endmodule
